// ===== rtl/htlru_pkg.sv =====
package htlru_pkg;

   localparam int KEY_BYTES = 8;

   localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
   localparam logic [31:0] FNV_PRIME = 32'h01000193;

   localparam logic [2:0] REQ_SET    = 3'd0;
   localparam logic [2:0] REQ_GET    = 3'd1;
   localparam logic [2:0] REQ_DELETE = 3'd2;
   localparam logic [2:0] REQ_EXISTS = 3'd3;
   localparam logic [2:0] REQ_PURGE  = 3'd4;
   localparam logic [2:0] REQ_CLEAR  = 3'd5;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_NOT_FOUND = 3'd1;
   localparam logic [2:0] STS_EXPIRED   = 3'd2;
   localparam logic [2:0] STS_FULL      = 3'd3;
   localparam logic [2:0] STS_INVALID   = 3'd4;

   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_LIVE  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   localparam logic [1:0] LOOK_MISS   = 2'd0;
   localparam logic [1:0] LOOK_HIT    = 2'd1;
   localparam logic [1:0] LOOK_NOSLOT = 2'd2;

   localparam logic [1:0] CSR_ENTRY_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_EVICT_ON_FULL = 2'd1;
   localparam logic [1:0] CSR_EXPIRY_ENABLE = 2'd2;

   typedef struct packed {
      logic [1:0]  st;
      logic [31:0] hash;
      logic [63:0] key;
      logic [31:0] value;
      logic [31:0] expiry;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [31:0] hash;
      logic [63:0] key;
      logic        invalid;
   } key_info_type;

endpackage

// ===== rtl/htlru_if.sv =====
interface htlru_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [63:0] key_bytes;
   logic [2:0]  key_length;
   logic [31:0] value_word;
   logic [31:0] time_to_live;
   logic [31:0] time_now;

   modport source (output valid, req_type, key_bytes, key_length, value_word,
                   time_to_live, time_now, input ready);
   modport sink (input valid, req_type, key_bytes, key_length, value_word,
                 time_to_live, time_now, output ready);
endinterface

interface htlru_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] value_out;
   logic [6:0]  probe_collisions;
   logic        evicted;
   logic [6:0]  live_entries;

   modport source (output valid, status, value_out, probe_collisions, evicted,
                   live_entries, input ready);
   modport sink (input valid, status, value_out, probe_collisions, evicted,
                 live_entries, output ready);
endinterface

// ===== rtl/htlru_ram.sv =====
module htlru_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/htlru_hash.sv =====
module htlru_hash
   import htlru_pkg::*;
#(
   parameter int BUCKETS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [63:0]                key_bytes,
   input  logic [2:0]                 key_length,
   output logic                       done,
   output key_info_type               info,
   output logic [$clog2(BUCKETS)-1:0] start_idx
);

   localparam int IW = $clog2(BUCKETS);
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HASH = 2'd1;
   localparam logic [1:0] PH_MOD  = 2'd2;

   logic [1:0]    phase_ff, phase_in;
   logic [63:0]   kb_ff, kb_in;
   logic [2:0]    klen_ff, klen_in;
   logic [2:0]    len_ff, len_in;
   logic [31:0]   hash_ff, hash_in;
   logic [63:0]   key_ff, key_in;
   logic          invalid_ff, invalid_in;
   logic [31:0]   sh_ff, sh_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [IW-1:0] rem_ff, rem_in;
   logic          done_ff, done_in;
   logic [7:0]    cur_byte;
   logic [IW:0]   rem_t;

   assign cur_byte = kb_ff[{len_ff, 3'b000} +: 8];

   always_comb begin
      phase_in   = phase_ff;
      kb_in      = kb_ff;
      klen_in    = klen_ff;
      len_in     = len_ff;
      hash_in    = hash_ff;
      key_in     = key_ff;
      invalid_in = invalid_ff;
      sh_in      = sh_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      done_in    = 1'b0;
      rem_t      = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_HASH;
               kb_in    = key_bytes;
               klen_in  = key_length;
               len_in   = '0;
               hash_in  = FNV_BASIS;
               key_in   = '0;
            end
         end
         PH_HASH: begin
            if (len_ff != klen_ff && cur_byte != 8'd0) begin
               hash_in = (hash_ff ^ {24'd0, cur_byte}) * FNV_PRIME;
               key_in[{len_ff, 3'b000} +: 8] = cur_byte;
               len_in = len_ff + 3'd1;
            end else begin
               invalid_in = (len_ff == 3'd0) || (32'(len_ff) >= KEY_BYTES);
               sh_in      = hash_ff;
               cnt_in     = '0;
               rem_in     = '0;
               phase_in   = PH_MOD;
            end
         end
         PH_MOD: begin
            // Four restoring steps of the remainder per cycle, top bits first.
            rem_t = {1'b0, rem_ff};
            for (int j = 0; j < 4; j++) begin
               rem_t = {rem_t[IW-1:0], sh_ff[31-j]};
               if (rem_t >= (IW+1)'(BUCKETS)) begin
                  rem_t = rem_t - (IW+1)'(BUCKETS);
               end
            end
            rem_in = rem_t[IW-1:0];
            sh_in  = {sh_ff[27:0], 4'd0};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      kb_ff      <= kb_in;
      klen_ff    <= klen_in;
      len_ff     <= len_in;
      hash_ff    <= hash_in;
      key_ff     <= key_in;
      invalid_ff <= invalid_in;
      sh_ff      <= sh_in;
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
   end

   assign done         = done_ff;
   assign info.hash    = hash_ff;
   assign info.key     = key_ff;
   assign info.invalid = invalid_ff;
   assign start_idx    = rem_ff;

endmodule

// ===== rtl/hash_table_lru_evict_kv_top.sv =====
// Channel   Direction  Transfer when         Carries
// req_ch    in         valid & ready         request type, key, value, ttl, time
// rsp_ch    out        valid & ready         status, value, collisions, evicted, count
// apb       in         psel&penable&pwrite   entry_limit, evict_on_full, expiry_enable
//
// One request is worked on at a time. A keyed request hashes a key of up to seven
// bytes, reduces the hash to a bucket index, and then probes buckets one at a time,
// each probe bound by the single read port of the bucket memory. Purge (with expiry
// on), clear, an eviction scan and a clock wrap each sweep all buckets, with a read
// and a write step per bucket. After reset the block sweeps the memory to empty
// before taking requests; configuration writes are taken at any time. A held result
// does not block the next request from being accepted and worked on.
module hash_table_lru_evict_kv_top
   import htlru_pkg::*;
#(
   parameter int BUCKETS = 64
) (
   input  logic        clock,
   input  logic        reset,
   htlru_req_if.sink   req_ch,
   htlru_rsp_if.source rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = $clog2(BUCKETS);
   localparam int CW = IW + 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_HASH   = 4'd1;
   localparam logic [3:0] S_PR_RD  = 4'd2;
   localparam logic [3:0] S_PR_CHK = 4'd3;
   localparam logic [3:0] S_SW_RD  = 4'd4;
   localparam logic [3:0] S_SW_WR  = 4'd5;
   localparam logic [3:0] S_TOMB   = 4'd6;
   localparam logic [3:0] S_UPD    = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_CLEAR = 3'd1;
   localparam logic [2:0] OP_PURGE = 3'd2;
   localparam logic [2:0] OP_EVICT = 3'd3;
   localparam logic [2:0] OP_WRAP  = 3'd4;

   // Configuration registers.
   logic [5:0] limit_ff, limit_in;
   logic       evict_en_ff, evict_en_in;
   logic       exp_en_ff, exp_en_in;

   // Control and request context.
   logic [3:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [2:0]    rq_type_ff, rq_type_in;
   logic [31:0]   value_ff, value_in;
   logic [31:0]   ttl_ff, ttl_in;
   logic [31:0]   now_ff, now_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] start_ff, start_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] c_ff, c_in;
   logic [IW-1:0] tomb_ff, tomb_in;
   logic          have_tomb_ff, have_tomb_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [1:0]    look_ff, look_in;
   entry_type     hit_ent_ff, hit_ent_in;
   logic          ev_ff, ev_in;
   logic [IW-1:0] best_ff, best_in;
   logic [31:0]   best_stamp_ff, best_stamp_in;
   logic          any_ff, any_in;
   logic [IW-1:0] sw_ff, sw_in;
   logic [CW-1:0] total_ff, total_in;
   logic [31:0]   counter_ff, counter_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   vout_ff, vout_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [6:0]    rsp_coll_ff, rsp_coll_in;
   logic          rsp_ev_ff, rsp_ev_in;
   logic [6:0]    rsp_live_ff, rsp_live_in;

   // Bucket memory and hash unit.
   logic          ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   entry_type     ram_wdata, rd;
   logic          hu_start, hu_done;
   key_info_type  hu_info;
   logic [IW-1:0] hu_idx;

   logic          cfg_wr;
   logic          expired_rd;
   logic          look_done;
   logic [1:0]    look_res;
   logic [IW-1:0] look_slot;
   logic          go_stamp;

   htlru_ram #(.WIDTH($bits(entry_type)), .DEPTH(BUCKETS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rd)
   );

   htlru_hash #(.BUCKETS(BUCKETS)) u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (hu_start),
      .key_bytes  (req_ch.key_bytes),
      .key_length (req_ch.key_length),
      .done       (hu_done),
      .info       (hu_info),
      .start_idx  (hu_idx)
   );

   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      case (paddr[3:2])
         CSR_ENTRY_LIMIT:   prdata = {26'd0, limit_ff};
         CSR_EVICT_ON_FULL: prdata = {31'd0, evict_en_ff};
         CSR_EXPIRY_ENABLE: prdata = {31'd0, exp_en_ff};
         default:           prdata = 32'd0;
      endcase
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign hu_start     = req_ch.valid && req_ch.ready && (req_ch.req_type <= REQ_EXISTS);

   // An entry counts as expired only with expiry on and a nonzero expiry time.
   assign expired_rd = exp_en_ff && (rd.expiry != 32'd0) && (now_ff >= rd.expiry);

   always_comb begin
      limit_in      = limit_ff;
      evict_en_in   = evict_en_ff;
      exp_en_in     = exp_en_ff;
      state_in      = state_ff;
      op_in         = op_ff;
      rq_type_in    = rq_type_ff;
      value_in      = value_ff;
      ttl_in        = ttl_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      start_in      = start_ff;
      n_in          = n_ff;
      c_in          = c_ff;
      tomb_in       = tomb_ff;
      have_tomb_in  = have_tomb_ff;
      slot_in       = slot_ff;
      look_in       = look_ff;
      hit_ent_in    = hit_ent_ff;
      ev_in         = ev_ff;
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;
      any_in        = any_ff;
      sw_in         = sw_ff;
      total_in      = total_ff;
      counter_in    = counter_ff;
      status_in     = status_ff;
      vout_in       = vout_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_coll_in   = rsp_coll_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_live_in   = rsp_live_ff;
      ram_we        = 1'b0;
      ram_waddr     = sw_ff;
      ram_wdata     = '0;
      ram_raddr     = sw_ff;
      look_done     = 1'b0;
      look_res      = LOOK_MISS;
      look_slot     = idx_ff;
      go_stamp      = 1'b0;

      if (cfg_wr) begin
         case (paddr[3:2])
            CSR_ENTRY_LIMIT:   limit_in    = pwdata[5:0];
            CSR_EVICT_ON_FULL: evict_en_in = pwdata[0];
            CSR_EXPIRY_ENABLE: exp_en_in   = pwdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               rq_type_in = req_ch.req_type;
               value_in   = req_ch.value_word;
               ttl_in     = req_ch.time_to_live;
               now_in     = req_ch.time_now;
               status_in  = STS_OK;
               vout_in    = '0;
               c_in       = '0;
               ev_in      = 1'b0;
               sw_in      = '0;
               any_in     = 1'b0;
               case (req_ch.req_type)
                  REQ_SET, REQ_GET, REQ_DELETE, REQ_EXISTS: begin
                     state_in = S_HASH;
                  end
                  REQ_PURGE: begin
                     op_in    = OP_PURGE;
                     state_in = req_ch.req_type == REQ_PURGE && req_ch.time_now == req_ch.time_now
                                && exp_en_ff ? S_SW_RD : S_RESP;
                  end
                  REQ_CLEAR: begin
                     op_in    = OP_CLEAR;
                     state_in = S_SW_RD;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_HASH: begin
            if (hu_done) begin
               if (hu_info.invalid) begin
                  status_in = STS_INVALID;
                  state_in  = S_RESP;
               end else begin
                  start_in     = hu_idx;
                  idx_in       = hu_idx;
                  n_in         = '0;
                  c_in         = '0;
                  have_tomb_in = 1'b0;
                  state_in     = S_PR_RD;
               end
            end
         end
         S_PR_RD: begin
            ram_raddr = idx_ff;
            state_in  = S_PR_CHK;
         end
         S_PR_CHK: begin
            // One bucket of the linear probe per visit.
            if (rd.st == SLOT_EMPTY) begin
               look_done = 1'b1;
               look_res  = LOOK_MISS;
               look_slot = have_tomb_ff ? tomb_ff : idx_ff;
            end else if (rd.st == SLOT_LIVE && rd.hash == hu_info.hash
                         && rd.key == hu_info.key) begin
               look_done = 1'b1;
               look_res  = LOOK_HIT;
               look_slot = idx_ff;
            end else begin
               if (rd.st == SLOT_TOMB) begin
                  if (!have_tomb_ff) begin
                     have_tomb_in = 1'b1;
                     tomb_in      = idx_ff;
                  end
               end else begin
                  c_in = c_ff + CW'(1);
               end
               n_in   = n_ff + CW'(1);
               idx_in = (32'(idx_ff) == BUCKETS - 1) ? '0 : idx_ff + IW'(1);
               if (32'(n_ff) == BUCKETS - 1) begin
                  look_done = 1'b1;
                  look_res  = (have_tomb_in) ? LOOK_MISS : LOOK_NOSLOT;
                  look_slot = tomb_in;
               end else begin
                  state_in = S_PR_RD;
               end
            end

            if (look_done) begin
               look_in    = look_res;
               slot_in    = look_slot;
               hit_ent_in = rd;
               state_in   = S_RESP;
               case (rq_type_ff)
                  REQ_SET: begin
                     if (look_res != LOOK_HIT && !ev_ff
                         && 32'(total_ff) >= 32'(limit_ff)) begin
                        if (!evict_en_ff) begin
                           status_in = STS_FULL;
                        end else begin
                           op_in    = OP_EVICT;
                           sw_in    = '0;
                           any_in   = 1'b0;
                           state_in = S_SW_RD;
                        end
                     end else if (look_res == LOOK_NOSLOT) begin
                        status_in = STS_FULL;
                     end else begin
                        go_stamp = 1'b1;
                     end
                  end
                  REQ_GET, REQ_EXISTS: begin
                     if (look_res != LOOK_HIT) begin
                        status_in = STS_NOT_FOUND;
                     end else if (expired_rd) begin
                        status_in = STS_EXPIRED;
                     end else begin
                        if (rq_type_ff == REQ_GET) begin
                           vout_in = rd.value;
                        end
                        go_stamp = 1'b1;
                     end
                  end
                  REQ_DELETE: begin
                     if (look_res != LOOK_HIT) begin
                        status_in = STS_NOT_FOUND;
                     end else begin
                        best_in  = look_slot;
                        state_in = S_TOMB;
                     end
                  end
                  default: ;
               endcase
               // A stamp taken at the top of the clock first restamps all live entries.
               if (go_stamp) begin
                  if (counter_ff == 32'hFFFF_FFFF) begin
                     op_in    = OP_WRAP;
                     sw_in    = '0;
                     state_in = S_SW_RD;
                  end else begin
                     state_in = S_UPD;
                  end
               end
            end
         end
         S_SW_RD: begin
            ram_raddr = sw_ff;
            state_in  = S_SW_WR;
         end
         S_SW_WR: begin
            ram_waddr = sw_ff;
            case (op_ff)
               OP_INIT, OP_CLEAR: begin
                  ram_we = 1'b1;
               end
               OP_WRAP: begin
                  ram_wdata       = rd;
                  ram_wdata.stamp = 32'd1;
                  ram_we          = (rd.st == SLOT_LIVE);
               end
               OP_PURGE: begin
                  ram_wdata.st = SLOT_TOMB;
                  if (rd.st == SLOT_LIVE && expired_rd) begin
                     ram_we = 1'b1;
                     if (total_ff != '0) begin
                        total_in = total_ff - CW'(1);
                     end
                  end
               end
               OP_EVICT: begin
                  if (rd.st == SLOT_LIVE && (!any_ff || rd.stamp < best_stamp_ff)) begin
                     any_in        = 1'b1;
                     best_in       = sw_ff;
                     best_stamp_in = rd.stamp;
                  end
               end
               default: ;
            endcase
            if (32'(sw_ff) == BUCKETS - 1) begin
               case (op_ff)
                  OP_INIT: begin
                     state_in = S_IDLE;
                  end
                  OP_CLEAR: begin
                     total_in   = '0;
                     counter_in = 32'd1;
                     state_in   = S_RESP;
                  end
                  OP_WRAP: begin
                     counter_in = 32'd2;
                     state_in   = S_UPD;
                  end
                  OP_EVICT: begin
                     if (any_in) begin
                        ev_in    = 1'b1;
                        state_in = S_TOMB;
                     end else begin
                        status_in = STS_FULL;
                        state_in  = S_RESP;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end else begin
               sw_in    = sw_ff + IW'(1);
               state_in = S_SW_RD;
            end
         end
         S_TOMB: begin
            // Delete or eviction of a live entry; an eviction then probes again.
            ram_we       = 1'b1;
            ram_waddr    = best_ff;
            ram_wdata.st = SLOT_TOMB;
            if (total_ff != '0) begin
               total_in = total_ff - CW'(1);
            end
            if (rq_type_ff == REQ_SET) begin
               idx_in       = start_ff;
               n_in         = '0;
               c_in         = '0;
               have_tomb_in = 1'b0;
               state_in     = S_PR_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_UPD: begin
            ram_we    = 1'b1;
            ram_waddr = slot_ff;
            if (rq_type_ff == REQ_SET) begin
               ram_wdata.st     = SLOT_LIVE;
               ram_wdata.hash   = hu_info.hash;
               ram_wdata.key    = hu_info.key;
               ram_wdata.value  = value_ff;
               ram_wdata.expiry = (exp_en_ff && ttl_ff != 32'd0) ? now_ff + ttl_ff : 32'd0;
               if (look_ff != LOOK_HIT) begin
                  total_in = total_ff + CW'(1);
               end
            end else begin
               ram_wdata = hit_ent_ff;
            end
            ram_wdata.stamp = counter_ff;
            counter_in      = counter_ff + 32'd1;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = vout_ff;
               rsp_coll_in   = (status_ff == STS_INVALID) ? 7'd0 :
                               (32'(c_ff) > 32'd127) ? 7'd127 : 7'(c_ff);
               rsp_ev_in     = ev_ff;
               rsp_live_in   = 7'(total_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= 6'd48;
         evict_en_ff  <= 1'b1;
         exp_en_ff    <= 1'b1;
         state_ff     <= S_SW_RD;
         op_ff        <= OP_INIT;
         sw_ff        <= '0;
         total_ff     <= '0;
         counter_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         evict_en_ff  <= evict_en_in;
         exp_en_ff    <= exp_en_in;
         state_ff     <= state_in;
         op_ff        <= op_in;
         sw_ff        <= sw_in;
         total_ff     <= total_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rq_type_ff    <= rq_type_in;
      value_ff      <= value_in;
      ttl_ff        <= ttl_in;
      now_ff        <= now_in;
      idx_ff        <= idx_in;
      start_ff      <= start_in;
      n_ff          <= n_in;
      c_ff          <= c_in;
      tomb_ff       <= tomb_in;
      have_tomb_ff  <= have_tomb_in;
      slot_ff       <= slot_in;
      look_ff       <= look_in;
      hit_ent_ff    <= hit_ent_in;
      ev_ff         <= ev_in;
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
      any_ff        <= any_in;
      status_ff     <= status_in;
      vout_ff       <= vout_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_coll_ff   <= rsp_coll_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_live_ff   <= rsp_live_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.value_out        = rsp_value_ff;
   assign rsp_ch.probe_collisions = rsp_coll_ff;
   assign rsp_ch.evicted          = rsp_ev_ff;
   assign rsp_ch.live_entries     = rsp_live_ff;

endmodule
